[design/lltfm_pkg.sv]
// Shared types and constants for the LED life-test fault monitor.
// Used by every module of the block; has no dependencies of its own.
package lltfm_pkg;

  // Default number of monitored channels.
  localparam int unsigned CHANNELS_DEF = 8;

  // Depth of the result queue in front of the output port.
  localparam int unsigned OUT_DEPTH = 4;

  // Field widths fixed by the interface.
  localparam int unsigned CH_W     = 3;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned TICK_W   = 24;
  localparam int unsigned CFG_W    = 24;

  // Register reset values.
  localparam logic [SAMPLE_W-1:0] THR_RESET       = 12'd1000;
  localparam logic [CNT_W-1:0]    MAX_OVER_RESET  = 8'd5;
  localparam logic [CNT_W-1:0]    MAX_FLUCT_RESET = 8'd5;
  localparam logic [TICK_W-1:0]   STEP0_RESET     = 24'd20;
  localparam logic [TICK_W-1:0]   STEP1_RESET     = 24'd2000;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_THR0      = 3'd0,
    REG_THR1      = 3'd1,
    REG_MAX_OVER  = 3'd2,
    REG_MAX_FLUCT = 3'd3,
    REG_STEP0     = 3'd4,
    REG_STEP1     = 3'd5
  } cfg_reg_t;

  // Input function codes.
  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_BUTTON = 1'b1
  } func_t;

  // Alarm codes carried on the output.
  typedef enum logic [1:0] {
    ALM_RELEVANT     = 2'd0,
    ALM_NONREL_STEP1 = 2'd1,
    ALM_NONREL_STEP0 = 2'd2,
    ALM_ALL_FAILED   = 2'd3
  } alarm_code_t;

  // Fault state of one channel.
  typedef enum logic [1:0] {
    FK_NONE     = 2'd0,
    FK_RELEVANT = 2'd1,
    FK_NONREL   = 2'd2
  } fault_kind_t;

  // One entry of the per-channel state memory.
  typedef struct packed {
    logic [CNT_W-1:0] over_count;
    logic [CNT_W-1:0] fluct_count;
    fault_kind_t      fault_kind;
  } chan_entry_t;

  // One result beat.
  typedef struct packed {
    logic        alarm_valid;
    logic [2:0]  alarm_led;
    alarm_code_t alarm_code;
    logic        power_on;
    logic        running;
    logic        test_step;
    logic        last;
  } result_t;

  // Saturating increment of an 8-bit counter.
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] x);
    sat_inc = (x == {CNT_W{1'b1}}) ? x : x + CNT_W'(1);
  endfunction

endpackage

[design/lltfm_chan_mem.sv]
// Per-channel state memory: over count, fluctuation count and fault kind.
// One read and one write port, registered read with write-first bypass.
// Depends on lltfm_pkg.
module lltfm_chan_mem #(
  parameter int unsigned CHANNELS = lltfm_pkg::CHANNELS_DEF,
  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   rd_en,
  input  logic [AW-1:0]          rd_addr,
  output lltfm_pkg::chan_entry_t rd_data,
  input  logic                   wr_en,
  input  logic [AW-1:0]          wr_addr,
  input  lltfm_pkg::chan_entry_t wr_data
);

  lltfm_pkg::chan_entry_t mem [CHANNELS];
  logic [CHANNELS-1:0]    written;

  // Storage write.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Entries read as zero until first written.
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (wr_en) begin
      written[wr_addr] <= 1'b1;
    end
  end

  // Registered read; a write to the same entry in the same cycle wins.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr_en && (wr_addr == rd_addr)) begin
        rd_data <= wr_data;
      end else if (written[rd_addr]) begin
        rd_data <= mem[rd_addr];
      end else begin
        rd_data <= '0;
      end
    end
  end

endmodule

[design/lltfm_out_fifo.sv]
// Result queue: takes up to two result beats per cycle, releases one per cycle while dout_ready is high.
// The producer only pushes while at least two entries are free.
// Depends on lltfm_pkg.
module lltfm_out_fifo (
  input  logic               clk,
  input  logic               rst,
  input  logic               push0,
  input  logic               push1,
  input  lltfm_pkg::result_t din0,
  input  lltfm_pkg::result_t din1,
  output logic               room2,
  output logic               dout_valid,
  input  logic               dout_ready,
  output lltfm_pkg::result_t dout
);

  localparam int unsigned PW = $clog2(lltfm_pkg::OUT_DEPTH);
  localparam int unsigned CW = $clog2(lltfm_pkg::OUT_DEPTH + 1);

  lltfm_pkg::result_t q [lltfm_pkg::OUT_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          pop;
  logic [CW-1:0] n_push;

  assign pop        = dout_valid && dout_ready;
  assign dout_valid = (count != '0);
  assign dout       = q[rd_ptr];
  assign room2      = (count <= CW'(lltfm_pkg::OUT_DEPTH - 2));
  assign n_push     = CW'(push0) + CW'(push1);

  // Entry writes.
  always_ff @(posedge clk) begin
    if (push0) begin
      q[wr_ptr] <= din0;
    end
    if (push1) begin
      q[wr_ptr + PW'(1)] <= din1;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(n_push);
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      count <= count + n_push - CW'(pop);
    end
  end

  // The queue never overfills.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(lltfm_pkg::OUT_DEPTH))
    else $error("result queue overflow");

  // Second push only together with the first.
  a_push_order: assert property (@(posedge clk) disable iff (rst)
    push1 |-> push0)
    else $error("second push without first");

  // Any push needs two free entries.
  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push0 |-> room2)
    else $error("push without room");

endmodule

[design/led_life_test_fault_monitor.sv]
// Top level of the LED life-test fault monitor: configuration registers,
// evaluation stage and global test state. Uses lltfm_chan_mem, lltfm_out_fifo
// and lltfm_pkg.
//
//   port group  dir  beat carries
//   in_*        in   func, channel, sample
//   cfg_*       in   cfg_index, cfg_data (register write)
//   out_*       out  alarm_valid, alarm_led, alarm_code, power_on, running,
//                    test_step, last
//
// An input beat is accepted every cycle unless the input stalls; it reads its
// channel's entry from the state memory at acceptance and is evaluated and
// written back as it leaves the evaluation stage. An item yields one or two
// result beats; a four-entry result queue absorbs output stalls, and input
// stalls only with fewer than two free queue entries. cfg_ready is always high.
// Synchronous reset clears all state at once; no clearing pass is needed.
module led_life_test_fault_monitor #(
  parameter int unsigned CHANNELS = lltfm_pkg::CHANNELS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              func,
  input  logic [lltfm_pkg::CH_W-1:0]        channel,
  input  logic [lltfm_pkg::SAMPLE_W-1:0]    sample,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [2:0]                        cfg_index,
  input  logic [lltfm_pkg::CFG_W-1:0]       cfg_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              alarm_valid,
  output logic [2:0]                        alarm_led,
  output logic [1:0]                        alarm_code,
  output logic                              power_on,
  output logic                              running,
  output logic                              test_step,
  output logic                              last
);

  localparam int unsigned AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned FW = $clog2(CHANNELS + 1);
  localparam int unsigned CNT_W  = lltfm_pkg::CNT_W;
  localparam int unsigned TICK_W = lltfm_pkg::TICK_W;
  localparam int unsigned SMP_W  = lltfm_pkg::SAMPLE_W;

  // Configuration registers.
  logic [SMP_W-1:0]  thr0;
  logic [SMP_W-1:0]  thr1;
  logic [CNT_W-1:0]  max_over;
  logic [CNT_W-1:0]  max_fluct;
  logic [TICK_W-1:0] step0_ticks;
  logic [TICK_W-1:0] step1_ticks;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr0        <= lltfm_pkg::THR_RESET;
      thr1        <= lltfm_pkg::THR_RESET;
      max_over    <= lltfm_pkg::MAX_OVER_RESET;
      max_fluct   <= lltfm_pkg::MAX_FLUCT_RESET;
      step0_ticks <= lltfm_pkg::STEP0_RESET;
      step1_ticks <= lltfm_pkg::STEP1_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (lltfm_pkg::cfg_reg_t'(cfg_index))
        lltfm_pkg::REG_THR0:      thr0        <= cfg_data[SMP_W-1:0];
        lltfm_pkg::REG_THR1:      thr1        <= cfg_data[SMP_W-1:0];
        lltfm_pkg::REG_MAX_OVER:  max_over    <= cfg_data[CNT_W-1:0];
        lltfm_pkg::REG_MAX_FLUCT: max_fluct   <= cfg_data[CNT_W-1:0];
        lltfm_pkg::REG_STEP0:     step0_ticks <= cfg_data[TICK_W-1:0];
        lltfm_pkg::REG_STEP1:     step1_ticks <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  // Acceptance and memory read.
  logic in_fire;
  logic in_range;
  logic s1_valid;
  logic s1_adv;
  logic room2;

  assign in_fire  = in_valid && in_ready;
  assign in_range = ({1'b0, channel} < (lltfm_pkg::CH_W + 1)'(CHANNELS));
  assign s1_adv   = s1_valid && room2;
  assign in_ready = !s1_valid || s1_adv;

  // Evaluation stage registers.
  logic                     s1_func;
  logic [lltfm_pkg::CH_W-1:0] s1_ch;
  logic [SMP_W-1:0]         s1_sample;
  logic                     s1_in_range;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_func     <= func;
      s1_ch       <= channel;
      s1_sample   <= sample;
      s1_in_range <= in_range;
    end
  end

  lltfm_pkg::chan_entry_t rd_entry;
  lltfm_pkg::chan_entry_t wr_entry;
  logic                   wr_en;

  lltfm_chan_mem #(
    .CHANNELS (CHANNELS)
  ) u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_fire && in_range),
    .rd_addr (channel[AW-1:0]),
    .rd_data (rd_entry),
    .wr_en   (wr_en),
    .wr_addr (s1_ch[AW-1:0]),
    .wr_data (wr_entry)
  );

  // Global test state.
  logic              step_now,      step_now_next;
  logic [TICK_W-1:0] tick_count,    tick_count_next;
  logic              run_flag,      run_flag_next;
  logic              power_flag,    power_flag_next;
  logic              tick_active,   tick_active_next;
  logic              tick_counting, tick_counting_next;
  logic [FW-1:0]     failed,        failed_next;

  logic                  ch_alarm;
  logic [2:0]            ch_led;
  lltfm_pkg::alarm_code_t ch_code;
  logic                  fail_alarm;

  // Evaluation of one item against the global state and its channel entry.
  always_comb begin
    logic [SMP_W-1:0]  thr;
    logic [TICK_W-1:0] len;
    logic [CNT_W-1:0]  oc;
    logic [CNT_W-1:0]  fc;
    logic              over_fault;

    thr = step_now ? thr1 : thr0;
    len = step_now ? step1_ticks : step0_ticks;
    oc  = rd_entry.over_count;
    fc  = rd_entry.fluct_count;
    over_fault = 1'b0;

    step_now_next      = step_now;
    tick_count_next    = tick_count;
    run_flag_next      = run_flag;
    power_flag_next    = power_flag;
    tick_active_next   = tick_active;
    tick_counting_next = tick_counting;
    failed_next        = failed;
    wr_en              = 1'b0;
    wr_entry           = rd_entry;
    ch_alarm           = 1'b0;
    ch_led             = s1_ch;
    ch_code            = lltfm_pkg::ALM_RELEVANT;
    fail_alarm         = 1'b0;

    if (lltfm_pkg::func_t'(s1_func) == lltfm_pkg::FUNC_BUTTON) begin
      if (tick_count >= len) begin
        step_now_next   = !step_now;
        tick_count_next = '0;
      end
      run_flag_next   = 1'b1;
      power_flag_next = 1'b1;
    end else if (s1_in_range) begin
      // Channel 0 opens a tick.
      if (s1_ch == '0) begin
        if (run_flag) begin
          tick_active_next = 1'b1;
          if (tick_count < len) begin
            tick_count_next    = tick_count + TICK_W'(1);
            tick_counting_next = 1'b1;
          end else begin
            tick_counting_next = 1'b0;
            power_flag_next    = 1'b0;
            run_flag_next      = 1'b0;
          end
        end else begin
          tick_active_next   = 1'b0;
          tick_counting_next = 1'b0;
        end
      end

      if (tick_active_next) begin
        // Over and fluctuation counting for a healthy channel.
        if (tick_counting_next && (rd_entry.fault_kind == lltfm_pkg::FK_NONE)) begin
          wr_en = s1_adv;
          if (s1_sample > thr) begin
            oc = lltfm_pkg::sat_inc(oc);
            if (oc > max_over) begin
              over_fault = 1'b1;
              wr_entry.fault_kind = step_now ? lltfm_pkg::FK_RELEVANT
                                             : lltfm_pkg::FK_NONREL;
              ch_alarm = 1'b1;
              ch_code  = step_now ? lltfm_pkg::ALM_RELEVANT
                                  : lltfm_pkg::ALM_NONREL_STEP0;
            end
          end else if (step_now && (oc != '0)) begin
            fc = lltfm_pkg::sat_inc(fc);
            oc = '0;
          end
          if (!over_fault && step_now && (fc > max_fluct)) begin
            wr_entry.fault_kind = lltfm_pkg::FK_NONREL;
            ch_alarm = 1'b1;
            ch_code  = lltfm_pkg::ALM_NONREL_STEP1;
          end
          wr_entry.over_count  = oc;
          wr_entry.fluct_count = fc;
          if (ch_alarm) begin
            failed_next = failed + FW'(1);
          end
        end

        // Last channel closes the tick.
        if (s1_ch == lltfm_pkg::CH_W'(CHANNELS - 1)) begin
          fail_alarm         = (failed_next == FW'(CHANNELS));
          tick_active_next   = 1'b0;
          tick_counting_next = 1'b0;
        end
      end

      if (ch_alarm || fail_alarm) begin
        run_flag_next   = 1'b0;
        power_flag_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step_now      <= 1'b0;
      tick_count    <= '0;
      run_flag      <= 1'b0;
      power_flag    <= 1'b0;
      tick_active   <= 1'b0;
      tick_counting <= 1'b0;
      failed        <= '0;
    end else if (s1_adv) begin
      step_now      <= step_now_next;
      tick_count    <= tick_count_next;
      run_flag      <= run_flag_next;
      power_flag    <= power_flag_next;
      tick_active   <= tick_active_next;
      tick_counting <= tick_counting_next;
      failed        <= failed_next;
    end
  end

  // Result beats of the item.
  lltfm_pkg::result_t res0;
  lltfm_pkg::result_t res1;

  always_comb begin
    res0 = '0;
    res1 = '0;
    res0.power_on  = power_flag_next;
    res0.running   = run_flag_next;
    res0.test_step = step_now_next;
    res1.power_on  = power_flag_next;
    res1.running   = run_flag_next;
    res1.test_step = step_now_next;
    res1.alarm_valid = 1'b1;
    res1.alarm_code  = lltfm_pkg::ALM_ALL_FAILED;
    res1.last        = 1'b1;
    if (ch_alarm) begin
      res0.alarm_valid = 1'b1;
      res0.alarm_led   = ch_led;
      res0.alarm_code  = ch_code;
      res0.last        = !fail_alarm;
    end else if (fail_alarm) begin
      res0.alarm_valid = 1'b1;
      res0.alarm_code  = lltfm_pkg::ALM_ALL_FAILED;
      res0.last        = 1'b1;
    end else begin
      res0.last = 1'b1;
    end
  end

  lltfm_pkg::result_t dout;

  lltfm_out_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push0      (s1_adv),
    .push1      (s1_adv && ch_alarm && fail_alarm),
    .din0       (res0),
    .din1       (res1),
    .room2      (room2),
    .dout_valid (out_valid),
    .dout_ready (out_ready),
    .dout       (dout)
  );

  assign alarm_valid = dout.alarm_valid;
  assign alarm_led   = dout.alarm_led;
  assign alarm_code  = dout.alarm_code;
  assign power_on    = dout.power_on;
  assign running     = dout.running;
  assign test_step   = dout.test_step;
  assign last        = dout.last;

  // Failed-channel count never exceeds the channel count.
  a_failed_bound: assert property (@(posedge clk) disable iff (rst)
    failed <= FW'(CHANNELS))
    else $error("failed channel count out of range");

  // Any alarm stops the run on the following cycle.
  a_alarm_stops: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && (ch_alarm || fail_alarm)) |=> (!run_flag && !power_flag))
    else $error("alarm did not stop the run");

  // Input is held back only while an item waits in evaluation.
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (s1_valid && !room2))
    else $error("input stalled without cause");

  // A channel alarm is always a freshly written fault.
  a_alarm_writes: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && ch_alarm) |-> (wr_en && (wr_entry.fault_kind != lltfm_pkg::FK_NONE)))
    else $error("channel alarm without fault write");

endmodule

[dv/led_life_test_fault_monitor_tb.sv]
// Self-checking testbench for the LED life-test fault monitor: a queue-fed driver,
// a result monitor and a beat-level predictor of the two-step life test.
// Depends on lltfm_pkg and the led_life_test_fault_monitor top level.
module led_life_test_fault_monitor_tb;
  import lltfm_pkg::*;

  localparam int CHAN_COUNT = CHANNELS_DEF;
  localparam int QUIET_LIMIT = 3000;
  localparam int PRINT_CAP = 40;

  typedef struct {
    func_t       f;
    logic [2:0]  ch;
    logic [11:0] value;
  } sensor_item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = 1'b0;
  logic [CH_W-1:0] channel = '0;
  logic [SAMPLE_W-1:0] sample = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [2:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic alarm_valid;
  logic [2:0] alarm_led;
  logic [1:0] alarm_code;
  logic power_on;
  logic running;
  logic test_step;
  logic last;

  // Stimulus queue, expected results and run control.
  sensor_item_t sensor_q[$];
  result_t pending_results[$];
  bit hold_input = 1'b0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  logic in_took = 1'b0;
  logic cfg_took = 1'b0;

  // Predictor copy of the registers and the test state.
  logic [11:0] thr0_cfg, thr1_cfg;
  logic [7:0] max_over_cfg, max_fluct_cfg;
  logic [23:0] len0_cfg, len1_cfg;
  logic step_st, run_st, power_st, tick_on, tick_counting;
  logic [23:0] ticks_st;
  logic [7:0] over_st [CHAN_COUNT];
  logic [7:0] fluct_st [CHAN_COUNT];
  fault_kind_t fault_st [CHAN_COUNT];
  int n_alarms;
  logic [2:0] hit_led [2];
  alarm_code_t hit_code [2];

  // Run statistics.
  int mismatches = 0;
  int in_beats = 0;
  int out_beats = 0;
  int alarm_beats = 0;
  int all_failed_beats = 0;
  int live_items = 0;
  int step_changes = 0;
  int quiet_cycles = 0;

  led_life_test_fault_monitor dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .func(func), .channel(channel), .sample(sample),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_ready(out_ready),
    .alarm_valid(alarm_valid), .alarm_led(alarm_led), .alarm_code(alarm_code),
    .power_on(power_on), .running(running), .test_step(test_step), .last(last)
  );

  always #5 clk = ~clk;

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("MISMATCH at result beat %0d: %s expected %0d got %0d",
               out_beats, what, want, got);
  endtask

  // An alarm records the channel and code, and always stops the run.
  function automatic void raise_alarm(logic [2:0] led, alarm_code_t code);
    if (n_alarms < 2) begin
      hit_led[n_alarms] = led;
      hit_code[n_alarms] = code;
      n_alarms++;
    end
    run_st = 1'b0;
    power_st = 1'b0;
  endfunction

  // Over and fluctuation counting for one healthy channel.
  function automatic void judge_channel(logic [2:0] ch, logic [11:0] value);
    logic [11:0] thr;
    thr = step_st ? thr1_cfg : thr0_cfg;
    if (fault_st[ch] != FK_NONE) return;
    if (value > thr) begin
      if (over_st[ch] != 8'hFF) over_st[ch]++;
      if (over_st[ch] > max_over_cfg) begin
        // A fault on the over count skips the fluctuation check.
        fault_st[ch] = step_st ? FK_RELEVANT : FK_NONREL;
        raise_alarm(ch, step_st ? ALM_RELEVANT : ALM_NONREL_STEP0);
        return;
      end
    end else if (step_st && over_st[ch] != 8'd0) begin
      if (fluct_st[ch] != 8'hFF) fluct_st[ch]++;
      over_st[ch] = 8'd0;
    end
    if (step_st && fluct_st[ch] > max_fluct_cfg) begin
      fault_st[ch] = FK_NONREL;
      raise_alarm(ch, ALM_NONREL_STEP1);
    end
  endfunction

  // Advances the life test by one input beat and queues the result beats it causes.
  function automatic void life_test_step(func_t f, logic [2:0] ch, logic [11:0] value);
    logic [23:0] len;
    int failed;
    int n;
    result_t r;
    n_alarms = 0;
    failed = 0;
    len = step_st ? len1_cfg : len0_cfg;
    if (f == FUNC_BUTTON) begin
      if (ticks_st >= len) begin
        step_st = ~step_st;
        ticks_st = '0;
        step_changes++;
      end
      run_st = 1'b1;
      power_st = 1'b1;
      live_items++;
    end else begin
      // Channel 0 opens a tick, which counts only while the step timer runs.
      if (ch == 3'd0) begin
        if (run_st) begin
          tick_on = 1'b1;
          if (ticks_st < len) begin
            ticks_st = ticks_st + 24'd1;
            tick_counting = 1'b1;
          end else begin
            tick_counting = 1'b0;
            power_st = 1'b0;
            run_st = 1'b0;
          end
        end else begin
          tick_on = 1'b0;
          tick_counting = 1'b0;
        end
      end
      if (tick_on) begin
        live_items++;
        if (tick_counting) judge_channel(ch, value);
        if (ch == 3'(CHAN_COUNT - 1)) begin
          for (int j = 0; j < CHAN_COUNT; j++)
            if (fault_st[j] != FK_NONE) failed++;
          if (failed == CHAN_COUNT) raise_alarm(3'd0, ALM_ALL_FAILED);
          tick_on = 1'b0;
          tick_counting = 1'b0;
        end
      end
    end
    n = (n_alarms > 0) ? n_alarms : 1;
    for (int k = 0; k < n; k++) begin
      r.alarm_valid = (n_alarms > 0);
      r.alarm_led = (n_alarms > 0) ? hit_led[k] : 3'd0;
      r.alarm_code = (n_alarms > 0) ? hit_code[k] : ALM_RELEVANT;
      r.power_on = power_st;
      r.running = run_st;
      r.test_step = step_st;
      r.last = (k == n - 1);
      pending_results.push_back(r);
    end
  endfunction

  // Rising edge: check result beats, track register writes, predict accepted beats.
  always @(posedge clk) begin : sample_edge
    result_t got;
    result_t want;
    if (rst) begin
      thr0_cfg = THR_RESET;
      thr1_cfg = THR_RESET;
      max_over_cfg = MAX_OVER_RESET;
      max_fluct_cfg = MAX_FLUCT_RESET;
      len0_cfg = STEP0_RESET;
      len1_cfg = STEP1_RESET;
      step_st = 1'b0;
      ticks_st = '0;
      run_st = 1'b0;
      power_st = 1'b0;
      tick_on = 1'b0;
      tick_counting = 1'b0;
      for (int j = 0; j < CHAN_COUNT; j++) begin
        over_st[j] = '0;
        fluct_st[j] = '0;
        fault_st[j] = FK_NONE;
      end
      in_took <= 1'b0;
      cfg_took <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      in_took <= in_valid && in_ready;
      cfg_took <= cfg_valid && cfg_ready;

      if (out_valid && out_ready) begin
        got.alarm_valid = alarm_valid;
        got.alarm_led = alarm_led;
        got.alarm_code = alarm_code_t'(alarm_code);
        got.power_on = power_on;
        got.running = running;
        got.test_step = test_step;
        got.last = last;
        if (alarm_valid) alarm_beats++;
        if (alarm_valid && got.alarm_code == ALM_ALL_FAILED) all_failed_beats++;
        if (pending_results.size() == 0) begin
          report_mismatch("result beat with nothing expected", 0, 0);
        end else begin
          want = pending_results.pop_front();
          if (got.alarm_valid !== want.alarm_valid)
            report_mismatch("alarm_valid", want.alarm_valid, got.alarm_valid);
          if (got.alarm_led !== want.alarm_led)
            report_mismatch("alarm_led", want.alarm_led, got.alarm_led);
          if (got.alarm_code !== want.alarm_code)
            report_mismatch("alarm_code", want.alarm_code, got.alarm_code);
          if (got.power_on !== want.power_on)
            report_mismatch("power_on", want.power_on, got.power_on);
          if (got.running !== want.running)
            report_mismatch("running", want.running, got.running);
          if (got.test_step !== want.test_step)
            report_mismatch("test_step", want.test_step, got.test_step);
          if (got.last !== want.last)
            report_mismatch("last", want.last, got.last);
        end
        out_beats++;
      end

      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_THR0:      thr0_cfg = cfg_data[11:0];
          REG_THR1:      thr1_cfg = cfg_data[11:0];
          REG_MAX_OVER:  max_over_cfg = cfg_data[7:0];
          REG_MAX_FLUCT: max_fluct_cfg = cfg_data[7:0];
          REG_STEP0:     len0_cfg = cfg_data[23:0];
          REG_STEP1:     len1_cfg = cfg_data[23:0];
          default: ;
        endcase
      end

      if (in_valid && in_ready) begin
        life_test_step(func_t'(func), channel, sample);
        in_beats++;
      end

      // Watchdog: too long without any beat on any channel ends the run.
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= QUIET_LIMIT) begin
        $display("Timeout: no beat accepted for %0d cycles", QUIET_LIMIT);
        $display("led_life_test_fault_monitor verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Falling edge: present the next sensor beat, holding it until accepted.
  always @(negedge clk) begin : feed_samples
    sensor_item_t nxt;
    if (!rst && (!in_valid || in_took)) begin
      if (sensor_q.size() != 0 && !hold_input && $urandom_range(99) >= send_idle_pct) begin
        nxt = sensor_q.pop_front();
        in_valid <= 1'b1;
        func <= nxt.f;
        channel <= nxt.ch;
        sample <= nxt.value;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Falling edge: random back-pressure on the result port.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  function automatic void push_item(func_t f, int ch, int value);
    sensor_item_t it;
    it.f = f;
    it.ch = 3'(ch);
    it.value = 12'(value);
    sensor_q.push_back(it);
  endfunction

  // Sensor level mostly just around the current threshold, sometimes at the rails.
  function automatic int pick_level();
    int thr;
    int v;
    thr = step_st ? int'(thr1_cfg) : int'(thr0_cfg);
    case ($urandom_range(9))
      0: v = 0;
      1: v = 4095;
      2, 3, 4, 5: v = thr + int'($urandom_range(40, 1));
      default: v = thr - int'($urandom_range(40, 0));
    endcase
    if (v > 4095) v = 4095;
    if (v < 0) v = 0;
    return v;
  endfunction

  // Random beat: the noise between well-formed ticks.
  function automatic void push_noise();
    push_item(($urandom_range(3) == 0) ? FUNC_BUTTON : FUNC_SAMPLE,
              $urandom_range(7), $urandom_range(4095));
  endfunction

  // One session: a button press and a few ticks in channel order,
  // with occasional missing presses, cut-short ticks and noise.
  function automatic void queue_session();
    int ticks;
    int stop_at;
    if ($urandom_range(9) != 0) push_item(FUNC_BUTTON, $urandom_range(7), $urandom_range(4095));
    ticks = $urandom_range(6, 1);
    for (int t = 0; t < ticks; t++) begin
      stop_at = ($urandom_range(15) == 0) ? $urandom_range(6) : CHAN_COUNT - 1;
      for (int c = 0; c <= stop_at; c++) begin
        push_item(FUNC_SAMPLE, c, pick_level());
        if ($urandom_range(24) == 0) push_noise();
      end
    end
  endfunction

  task automatic write_reg(input cfg_reg_t idx, input int unsigned val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    do @(negedge clk); while (!cfg_took);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_limits(input int unsigned t0, input int unsigned t1,
                            input int unsigned mo, input int unsigned mf,
                            input int unsigned s0, input int unsigned s1);
    write_reg(REG_THR0, t0);
    write_reg(REG_THR1, t1);
    write_reg(REG_MAX_OVER, mo);
    write_reg(REG_MAX_FLUCT, mf);
    write_reg(REG_STEP0, s0);
    write_reg(REG_STEP1, s1);
  endtask

  // Wait until every queued beat went in and every expected result came out.
  task automatic drain();
    while (sensor_q.size() != 0 || in_valid || pending_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_phase(input int send_pct, input int stall_pct, input int goal,
                           input bit pause_midway);
    int start;
    bit paused;
    start = in_beats;
    paused = 1'b0;
    send_idle_pct = send_pct;
    recv_stall_pct = stall_pct;
    while (in_beats - start < goal) begin
      // Let the block run completely dry once before continuing.
      if (pause_midway && !paused && in_beats - start >= goal / 2) begin
        hold_input = 1'b1;
        while (in_valid || pending_results.size() != 0) @(posedge clk);
        hold_input = 1'b0;
        paused = 1'b1;
      end
      queue_session();
      while (sensor_q.size() > 16) @(negedge clk);
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: ignored samples, start, faults in both steps, a mid-tick
    // alarm, channel 0 restarting a tick, step expiry and step switching.
    set_limits(2000, 2000, 0, 0, 1, 2);
    push_item(FUNC_SAMPLE, 0, 4095);
    push_item(FUNC_SAMPLE, 3, 0);
    push_item(FUNC_BUTTON, 0, 0);
    push_item(FUNC_SAMPLE, 0, 0);
    push_item(FUNC_SAMPLE, 1, 2000);
    push_item(FUNC_SAMPLE, 2, 4095);
    push_item(FUNC_SAMPLE, 3, 0);
    push_item(FUNC_SAMPLE, 7, 0);
    push_item(FUNC_SAMPLE, 0, 0);
    push_item(FUNC_BUTTON, 7, 4095);
    push_item(FUNC_SAMPLE, 0, 0);
    push_item(FUNC_SAMPLE, 0, 0);
    push_item(FUNC_SAMPLE, 4, 4095);
    push_item(FUNC_SAMPLE, 0, 0);
    push_item(FUNC_BUTTON, 0, 0);
    push_item(FUNC_SAMPLE, 0, 0);
    push_item(FUNC_SAMPLE, 5, 0);
    push_item(FUNC_SAMPLE, 0, 0);
    push_item(FUNC_SAMPLE, 6, 4095);
    push_item(FUNC_SAMPLE, 7, 4095);
    push_item(FUNC_BUTTON, 0, 0);
    push_item(FUNC_SAMPLE, 0, 0);
    run_phase(0, 0, 0, 1'b0);

    // Random phases: lenient limits first while channels are healthy,
    // then tight limits that fault every channel.
    set_limits(1500, 1200, 254, 254, 4, 6);
    run_phase(0, 0, 370, 1'b1);
    set_limits(4095, 0, 254, 254, 3, 16777215);
    run_phase(82, 0, 370, 1'b0);
    set_limits(0, 4095, 254, 254, 16777215, 5);
    run_phase(0, 82, 370, 1'b0);
    set_limits(1000, 1000, 60, 3, 5, 4);
    run_phase(6, 6, 370, 1'b0);
    set_limits(2048, 2048, 0, 0, 2, 3);
    run_phase(0, 0, 370, 1'b0);

    repeat (8) @(posedge clk);
    $display("Run covered %0d input beats (%0d acted on) across six register settings",
             in_beats, live_items);
    $display("and four idle patterns; %0d result beats, %0d alarms, %0d all-failed,",
             out_beats, alarm_beats, all_failed_beats);
    $display("%0d step changes", step_changes);
    if (mismatches == 0) begin
      $display("led_life_test_fault_monitor verification clean");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("led_life_test_fault_monitor verification failed");
    end
    $finish;
  end

endmodule
